@@ design/bmpd_pkg.sv @@
// ----------------------------------------------------------------------------
// bmpd_pkg
// Types and constants shared by the 24-bit BMP stream decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

	localparam logic [15:0] SIG_BM   = 16'h4D42;
	localparam logic [31:0] INFO_LEN = 32'd40;
	localparam logic [15:0] BPP24    = 16'd24;
	localparam logic [31:0] HDR_LEN  = 32'd54;
	localparam int          QDEPTH   = 4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_SMALL = 3'd1;
	localparam logic [2:0] ST_BAD_SIG   = 3'd2;
	localparam logic [2:0] ST_BAD_HDR   = 3'd3;
	localparam logic [2:0] ST_BAD_OFF   = 3'd4;
	localparam logic [2:0] ST_TRUNC     = 3'd5;
	localparam logic [2:0] ST_SIZE      = 3'd6;

	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} in_word_t;

	typedef struct packed {
		logic        result_kind;
		logic [23:0] dest_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [2:0]  status;
		logic        last_flag;
	} out_word_t;

	// One accepted byte's worth of results: an optional pixel and an optional status.
	typedef struct packed {
		logic        has_pix;
		logic [23:0] index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        has_st;
		logic [12:0] width;
		logic [12:0] height;
		logic [2:0]  status;
	} entry_t;

endpackage

@@ design/bmpd_front.sv @@
// ----------------------------------------------------------------------------
// bmpd_front
// Header capture and check, pixel offset skip, row walk and pixel forming.
// ----------------------------------------------------------------------------
module bmpd_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  bmpd_pkg::in_word_t word,
	output logic               ent_valid,
	output bmpd_pkg::entry_t   ent
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int SW = $clog2(3 * MAX_WIDTH + 4);

	logic [31:0]   pos_q, pos_n;
	logic [15:0]   sig_q, sig_n;
	logic [31:0]   off_q, off_n, info_q, info_n, wid_q, wid_n, hgt_q, hgt_n;
	logic [15:0]   pln_q, pln_n, bpp_q, bpp_n;
	logic [31:0]   cmp_q, cmp_n;
	logic [2:0]    err_q, err_n;
	logic [SW-1:0] stride_q, stride_n, rowb_q, rowb_n, colb_q, colb_n;
	logic [1:0]    phase_q, phase_n;
	logic [HW-1:0] srow_q, srow_n, absh_q, absh_n;
	logic [WW-1:0] pcol_q, pcol_n, w_q, w_n;
	logic          flip_q, flip_n, mul_q, mul_n;
	logic [23:0]   rbase_q, rbase_n;
	logic [7:0]    hb_q, hb_n, hg_q, hg_n;

	logic [HW+WW-1:0] prod;
	logic [31:0]      abs32, lane_off;
	logic [SW-1:0]    colb_inc;
	logic [7:0]       b;

	assign prod = (absh_q - HW'(1)) * w_q;
	assign b    = word.data_byte;

	always_comb begin
		pos_n = pos_q; sig_n = sig_q; off_n = off_q; info_n = info_q;
		wid_n = wid_q; hgt_n = hgt_q; pln_n = pln_q; bpp_n = bpp_q;
		cmp_n = cmp_q; err_n = err_q; stride_n = stride_q; rowb_n = rowb_q;
		colb_n = colb_q; phase_n = phase_q; srow_n = srow_q; absh_n = absh_q;
		pcol_n = pcol_q; w_n = w_q; flip_n = flip_q; mul_n = 1'b0;
		rbase_n = rbase_q; hb_n = hb_q; hg_n = hg_q;
		ent_valid = 1'b0;
		ent = '0;
		abs32 = hgt_q[31] ? (~hgt_q + 32'd1) : hgt_q;
		lane_off = '0;
		colb_inc = colb_q + SW'(1);

		if (mul_q)
			rbase_n = flip_q ? 24'(prod) : 24'd0;

		if (accept) begin
			if (pos_q < bmpd_pkg::HDR_LEN) begin
				if (pos_q < 32'd2)
					sig_n[{pos_q[0], 3'b000} +: 8] = b;
				else if (pos_q >= 32'd10 && pos_q < 32'd34) begin
					lane_off = pos_q - 32'd10;
					unique case (lane_off[4:2])
						3'd0: off_n[{lane_off[1:0], 3'b000} +: 8] = b;
						3'd1: info_n[{lane_off[1:0], 3'b000} +: 8] = b;
						3'd2: wid_n[{lane_off[1:0], 3'b000} +: 8] = b;
						3'd3: hgt_n[{lane_off[1:0], 3'b000} +: 8] = b;
						3'd4: begin
							if (!lane_off[1])
								pln_n[{lane_off[0], 3'b000} +: 8] = b;
							else
								bpp_n[{lane_off[0], 3'b000} +: 8] = b;
						end
						default: cmp_n[{lane_off[1:0], 3'b000} +: 8] = b;
					endcase
				end
				if (pos_q == bmpd_pkg::HDR_LEN - 32'd1) begin
					priority if (sig_q != bmpd_pkg::SIG_BM)
						err_n = bmpd_pkg::ST_BAD_SIG;
					else if (info_q != bmpd_pkg::INFO_LEN || pln_q != 16'd1 ||
					         bpp_q != bmpd_pkg::BPP24 || cmp_q != 32'd0)
						err_n = bmpd_pkg::ST_BAD_HDR;
					else if (off_q < bmpd_pkg::HDR_LEN)
						err_n = bmpd_pkg::ST_BAD_OFF;
					else if (wid_q == 32'd0 || wid_q[31] ||
					         wid_q > 32'(MAX_WIDTH) || abs32 > 32'(MAX_HEIGHT))
						err_n = bmpd_pkg::ST_SIZE;
					else begin
						err_n    = bmpd_pkg::ST_OK;
						w_n      = WW'(wid_q);
						absh_n   = HW'(abs32);
						rowb_n   = SW'(wid_q * 32'd3);
						stride_n = SW'((wid_q * 32'd3 + 32'd3) & ~32'd3);
						flip_n   = hgt_q != 32'd0 && !hgt_q[31];
						colb_n   = '0;
						pcol_n   = '0;
						srow_n   = '0;
						phase_n  = '0;
						mul_n    = 1'b1;
					end
				end
			end else if (err_q == bmpd_pkg::ST_OK && pos_q >= off_q && srow_q < absh_q) begin
				if (colb_q < rowb_q) begin
					unique case (phase_q)
						2'd0: begin
							hb_n = b;
							phase_n = 2'd1;
						end
						2'd1: begin
							hg_n = b;
							phase_n = 2'd2;
						end
						default: begin
							ent_valid   = 1'b1;
							ent.has_pix = 1'b1;
							ent.index   = rbase_q + 24'(pcol_q);
							ent.red     = b;
							ent.green   = hg_q;
							ent.blue    = hb_q;
							pcol_n      = pcol_q + WW'(1);
							phase_n     = 2'd0;
						end
					endcase
				end
				colb_n = colb_inc;
				if (colb_inc >= stride_q) begin
					colb_n  = '0;
					pcol_n  = '0;
					phase_n = '0;
					srow_n  = srow_q + HW'(1);
					// step to the next destination row
					rbase_n = flip_q ? rbase_q - 24'(w_q) : rbase_q + 24'(w_q);
				end
			end

			if (pos_q != 32'hFFFF_FFFF)
				pos_n = pos_q + 32'd1;

			if (word.end_of_file) begin
				ent_valid = 1'b1;
				ent.has_st = 1'b1;
				priority if (pos_n < bmpd_pkg::HDR_LEN)
					ent.status = bmpd_pkg::ST_TOO_SMALL;
				else if (err_n != bmpd_pkg::ST_OK)
					ent.status = err_n;
				else if (pos_n <= off_q)
					ent.status = bmpd_pkg::ST_BAD_OFF;
				else if (srow_n < absh_n)
					ent.status = bmpd_pkg::ST_TRUNC;
				else
					ent.status = bmpd_pkg::ST_OK;
				if (ent.status == bmpd_pkg::ST_OK) begin
					ent.width  = 13'(w_n);
					ent.height = 13'(absh_n);
				end
				// drop all file state so the next byte starts a new file
				pos_n = '0; sig_n = '0; off_n = '0; info_n = '0; wid_n = '0;
				hgt_n = '0; pln_n = '0; bpp_n = '0; cmp_n = '0; err_n = '0;
				stride_n = '0; rowb_n = '0; colb_n = '0; phase_n = '0;
				srow_n = '0; absh_n = '0; pcol_n = '0; w_n = '0; flip_n = 1'b0;
				mul_n = 1'b0; rbase_n = '0; hb_n = '0; hg_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; sig_q <= '0; off_q <= '0; info_q <= '0; wid_q <= '0;
			hgt_q <= '0; pln_q <= '0; bpp_q <= '0; cmp_q <= '0; err_q <= '0;
			stride_q <= '0; rowb_q <= '0; colb_q <= '0; phase_q <= '0;
			srow_q <= '0; absh_q <= '0; pcol_q <= '0; w_q <= '0; flip_q <= 1'b0;
			mul_q <= 1'b0; rbase_q <= '0; hb_q <= '0; hg_q <= '0;
		end else begin
			pos_q <= pos_n; sig_q <= sig_n; off_q <= off_n; info_q <= info_n;
			wid_q <= wid_n; hgt_q <= hgt_n; pln_q <= pln_n; bpp_q <= bpp_n;
			cmp_q <= cmp_n; err_q <= err_n; stride_q <= stride_n; rowb_q <= rowb_n;
			colb_q <= colb_n; phase_q <= phase_n; srow_q <= srow_n; absh_q <= absh_n;
			pcol_q <= pcol_n; w_q <= w_n; flip_q <= flip_n; mul_q <= mul_n;
			rbase_q <= rbase_n; hb_q <= hb_n; hg_q <= hg_n;
		end
	end

endmodule

@@ design/bmpd_back.sv @@
// ----------------------------------------------------------------------------
// bmpd_back
// Entry queue; splits each entry into its pixel and status result words.
// ----------------------------------------------------------------------------
module bmpd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  bmpd_pkg::entry_t    ent,
	output logic                full,
	output logic                empty,
	input  logic                pop,
	output bmpd_pkg::out_word_t result
);

	localparam int AW = $clog2(bmpd_pkg::QDEPTH);

	bmpd_pkg::entry_t mem [bmpd_pkg::QDEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             sent_q;
	bmpd_pkg::entry_t head;
	logic             pix_now, deq;

	assign full    = cnt_q == (AW+1)'(bmpd_pkg::QDEPTH);
	assign empty   = cnt_q == '0;
	assign head    = mem[rp_q];
	assign pix_now = head.has_pix && !sent_q;
	// hold the entry after its pixel when a status follows
	assign deq     = pop && !empty && !(pix_now && head.has_st);

	always_comb begin
		result = '0;
		if (pix_now) begin
			result.result_kind = bmpd_pkg::KIND_PIXEL;
			result.dest_index  = head.index;
			result.red         = head.red;
			result.green       = head.green;
			result.blue        = head.blue;
			result.last_flag   = !head.has_st;
		end else begin
			result.result_kind  = bmpd_pkg::KIND_STATUS;
			result.image_width  = head.width;
			result.image_height = head.height;
			result.status       = head.status;
			result.last_flag    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr && !full)
			mem[wp_q] <= ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			cnt_q  <= '0;
			sent_q <= 1'b0;
		end else begin
			if (wr && !full)
				wp_q <= wp_q + AW'(1);
			if (deq)
				rp_q <= rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr && !full) - (AW+1)'(deq);
			if (deq)
				sent_q <= 1'b0;
			else if (pop && !empty)
				sent_q <= 1'b1;
		end
	end

endmodule

@@ design/bmp24_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// bmp24_stream_decoder
// Streaming decoder for uncompressed 24-bit BMP files.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive byte_word (data_byte, end_of_file) and push; a word is
//   taken on each edge with push high and full low, one byte per cycle.
//   Result queue: while empty is low, result holds the oldest result word;
//   pop high takes it. Pixels come out RGB with a top-down dest_index; the
//   byte marked end_of_file adds one status word after any pixel it makes.
//   Each result word enters the queue as the byte that makes it is taken.
//   Throughput: one byte per cycle while full is low, set by the header/row
//   walk in the front part; the end-of-file byte yields up to two words at
//   one word per pop. A four-entry queue sits between front and back; when
//   the receiver stalls, full rises once it fills and input waits.
//   Reset clears all file state and the queue; after each end-of-file byte
//   the decoder starts over for a new file. The row start of a bottom-up
//   image is one multiply in the cycle after the header is checked.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  bmpd_pkg::in_word_t  byte_word,
	output logic                empty,
	input  logic                pop,
	output bmpd_pkg::out_word_t result
);

	logic             accept, ent_valid;
	bmpd_pkg::entry_t ent;

	assign accept = push && !full;

	bmpd_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.word     (byte_word),
		.ent_valid(ent_valid),
		.ent      (ent)
	);

	bmpd_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (ent_valid),
		.ent   (ent),
		.full  (full),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

endmodule
